// ===== rtl/core/urr_pkg.sv =====
// ----------------------------------------------------------------------------
// urr_pkg
// shared constants, codes and types of the uart receive ring
// ----------------------------------------------------------------------------
package urr_pkg;

    localparam int unsigned RING_DEPTH = 64;
    localparam int unsigned PTR_W      = $clog2(RING_DEPTH);

    localparam logic [1:0] ACT_BYTE   = 2'd0;
    localparam logic [1:0] ACT_REQ    = 2'd1;
    localparam logic [1:0] ACT_CANCEL = 2'd2;

    localparam logic [2:0] KIND_DATA      = 3'd0;
    localparam logic [2:0] KIND_BUSY      = 3'd1;
    localparam logic [2:0] KIND_INVALID   = 3'd2;
    localparam logic [2:0] KIND_CANCELLED = 3'd3;
    localparam logic [2:0] KIND_NOTHING   = 3'd4;

    typedef logic [PTR_W-1:0] ptr_t;

    // one write port and one read port of the ring memory
    typedef struct packed {
        logic       we;
        ptr_t       waddr;
        logic [7:0] wdata;
        logic       re;
        ptr_t       raddr;
    } ring_req_t;

    // slot index plus one, wrapping at the ring depth
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(RING_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/core/urr_ring_mem.sv =====
// ----------------------------------------------------------------------------
// urr_ring_mem
// byte store of the receive ring, one write and one registered read port
// ----------------------------------------------------------------------------
module urr_ring_mem
    import urr_pkg::*;
(
    input  logic       clk,
    input  ring_req_t  req,
    output logic [7:0] rdata
);

    logic [7:0] mem [RING_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/uart_rx_ring_with_read_request.sv =====
// ----------------------------------------------------------------------------
// uart_rx_ring_with_read_request
// uart receive ring with read requests, overwrite-oldest when full
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command word: tuser is the action (byte received,
//   read request, cancel), tdata holds the received byte and the request
//   length. m_axis carries result words: tuser is the result kind, tdata
//   holds the delivered byte and the delivered count, tlast marks the byte
//   that completes a read request.
// timing
//   a command word is taken in idle and decoded in the cycle after; a
//   status word or a byte passed straight to the requester is loaded into
//   the output register from the exec state. a read request that finds
//   bytes in the ring (at most 63) goes on through a memory read state and
//   a wait state that sends its first byte; the rest follow one per cycle
//   while the output register is free, and the next command is taken once
//   all are out. other commands stay in exec while the result side stalls.
// reset
//   pointers, pending count and request length clear; the ring is empty.
//   no clearing pass is needed since only occupied slots are read.
// backpressure
//   a result waits in the output register; while it waits with
//   m_axis_tready low the block holds the current command, and takes
//   no new command until it is back in idle.
// ----------------------------------------------------------------------------
module uart_rx_ring_with_read_request
    import urr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // rx_data[7:0], request_length[23:8]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // data[7:0], delivered_count[23:8]
    output logic [2:0]  m_axis_tuser,   // kind[2:0]
    output logic        m_axis_tlast    // done_res
);

    typedef enum logic [3:0] {
        ST_IDLE       = 4'b0001,
        ST_EXEC       = 4'b0010,
        ST_DRAIN_RD   = 4'b0100,
        ST_DRAIN_WAIT = 4'b1000
    } state_t;

    localparam logic [PTR_W:0] DEPTH_W = (PTR_W + 1)'(RING_DEPTH);

    state_t      state_reg, state_next;
    ptr_t        wp_reg, wp_next;
    ptr_t        rp_reg, rp_next;
    logic [15:0] pend_reg, pend_next;
    logic [15:0] total_reg, total_next;
    ptr_t        fill_reg, fill_next;
    ptr_t        cnt_reg, cnt_next;

    // latched command word
    logic [1:0]  act_reg, act_next;
    logic [7:0]  byte_reg, byte_next;
    logic [15:0] len_reg, len_next;

    // output register
    logic        ovalid_reg, ovalid_next;
    logic [2:0]  okind_reg, okind_next;
    logic [7:0]  odata_reg, odata_next;
    logic        olast_reg, olast_next;
    logic [15:0] ocount_reg, ocount_next;

    ring_req_t   ring_req;
    logic [7:0]  ring_rdata;

    logic        out_free;
    logic        load;
    logic [PTR_W:0] avail_wide;
    ptr_t        avail;
    ptr_t        fill;
    ptr_t        cnt_inc;
    ptr_t        wp_inc;

    urr_ring_mem u_ring
    (
        .clk   (clk),
        .req   (ring_req),
        .rdata (ring_rdata)
    );

    assign out_free      = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    // bytes held in the ring and how many of them a request drains
    always_comb
    begin
        if (wp_reg >= rp_reg)
            avail_wide = {1'b0, wp_reg} - {1'b0, rp_reg};
        else
            avail_wide = {1'b0, wp_reg} + DEPTH_W - {1'b0, rp_reg};
        avail = avail_wide[PTR_W-1:0];
        if (16'(avail) < len_reg)
            fill = avail;
        else
            fill = len_reg[PTR_W-1:0];
    end

    assign cnt_inc = cnt_reg + 1'b1;
    assign wp_inc  = ptr_inc(wp_reg);

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        pend_next   = pend_reg;
        total_next  = total_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        act_next    = act_reg;
        byte_next   = byte_reg;
        len_next    = len_reg;
        load        = 1'b0;
        okind_next  = okind_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        ocount_next = ocount_reg;
        ring_req    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next   = s_axis_tuser;
                    byte_next  = s_axis_tdata[7:0];
                    len_next   = s_axis_tdata[23:8];
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    case (act_reg)
                        ACT_BYTE:
                        begin
                            if (pend_reg != '0)
                            begin
                                // bypass the ring straight to the requester
                                pend_next   = pend_reg - 1'b1;
                                load        = 1'b1;
                                okind_next  = KIND_DATA;
                                odata_next  = byte_reg;
                                olast_next  = (pend_reg == 16'd1);
                                ocount_next = total_reg - pend_next;
                            end
                            else
                            begin
                                ring_req.we    = 1'b1;
                                ring_req.waddr = wp_reg;
                                ring_req.wdata = byte_reg;
                                wp_next        = wp_inc;
                                // full ring drops its oldest byte
                                if (wp_inc == rp_reg)
                                    rp_next = ptr_inc(rp_reg);
                            end
                        end
                        ACT_REQ:
                        begin
                            if (len_reg == '0)
                            begin
                                load        = 1'b1;
                                okind_next  = KIND_INVALID;
                                odata_next  = '0;
                                olast_next  = 1'b0;
                                ocount_next = '0;
                            end
                            else if (pend_reg != '0)
                            begin
                                load        = 1'b1;
                                okind_next  = KIND_BUSY;
                                odata_next  = '0;
                                olast_next  = 1'b0;
                                ocount_next = '0;
                            end
                            else
                            begin
                                total_next = len_reg;
                                pend_next  = len_reg - 16'(fill);
                                fill_next  = fill;
                                cnt_next   = '0;
                                if (fill != '0)
                                    state_next = ST_DRAIN_RD;
                            end
                        end
                        ACT_CANCEL:
                        begin
                            load       = 1'b1;
                            odata_next = '0;
                            olast_next = 1'b0;
                            if (pend_reg != '0)
                            begin
                                total_next  = total_reg - pend_reg;
                                pend_next   = '0;
                                okind_next  = KIND_CANCELLED;
                                ocount_next = total_reg - pend_reg;
                            end
                            else
                            begin
                                okind_next  = KIND_NOTHING;
                                ocount_next = '0;
                            end
                        end
                        default:
                        begin
                            // unused action code: no effect
                        end
                    endcase
                end
            end

            ST_DRAIN_RD:
            begin
                ring_req.re    = 1'b1;
                ring_req.raddr = rp_reg;
                state_next     = ST_DRAIN_WAIT;
            end

            ST_DRAIN_WAIT:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    okind_next  = KIND_DATA;
                    odata_next  = ring_rdata;
                    olast_next  = (cnt_inc == fill_reg) && (16'(fill_reg) == len_reg);
                    ocount_next = 16'(cnt_inc);
                    rp_next     = ptr_inc(rp_reg);
                    cnt_next    = cnt_inc;
                    if (cnt_inc == fill_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the next slot while this byte goes out
                        ring_req.re    = 1'b1;
                        ring_req.raddr = ptr_inc(rp_reg);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
            ovalid_next = 1'b1;
        else if (m_axis_tready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wp_reg     <= '0;
            rp_reg     <= '0;
            pend_reg   <= '0;
            total_reg  <= '0;
            fill_reg   <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            pend_reg   <= pend_next;
            total_reg  <= total_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        byte_reg   <= byte_next;
        len_reg    <= len_next;
        okind_reg  <= okind_next;
        odata_reg  <= odata_next;
        olast_reg  <= olast_next;
        ocount_reg <= ocount_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tdata  = {ocount_reg, odata_reg};
    assign m_axis_tlast  = olast_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // the drain never runs past the bytes it found in the ring
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN_WAIT) |-> (cnt_reg < fill_reg))
        else $error("drain count ran past fill");

    // pointers stay inside the ring
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(wp_reg) < RING_DEPTH) && (32'(rp_reg) < RING_DEPTH))
        else $error("ring pointer out of range");

    // only a data word may complete a request
    a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_DATA))
        else $error("completion mark on a status word");

    // status words carry no byte
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_DATA)) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("status word with nonzero data");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the uart receive ring with read requests: drives
// byte, request, cancel and unused command words with random gaps, predicts
// every result word from its own copy of the ring and the pending request,
// and checks each word that leaves the block against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top
    import urr_pkg::*;
();

    // action code the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned RESET_CYCLES   = 11;
    // commands accepted over the whole run, ignored ones excluded
    localparam int unsigned TOTAL_COMMANDS = 130;
    // quiet time after the last due word, to catch stray words
    localparam int unsigned DRAIN_CYCLES   = 100;
    // generous: every word could wait out a long stall and still fit
    localparam int unsigned CYCLE_LIMIT    = 4_000_000;

    // one result word as it leaves the block
    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [15:0] count;
    } rx_word_t;

    // ------------------------------------------------------------------------
    // scoreboard: ring and request predictor plus the queue of due words
    // ------------------------------------------------------------------------
    class rx_ring_scoreboard;
        logic [7:0]  ring_bytes [RING_DEPTH];
        int unsigned wr_slot;
        int unsigned rd_slot;
        logic [15:0] owed;          // bytes still owed to the open request
        logic [15:0] req_len;       // length of the open request
        rx_word_t    due_words [$];
        int unsigned errors;
        int unsigned overruns;
        int unsigned words_by_kind [5];

        function new();
            wr_slot  = 0;
            rd_slot  = 0;
            owed     = '0;
            req_len  = '0;
            errors   = 0;
            overruns = 0;
            foreach (words_by_kind[k])
                words_by_kind[k] = 0;
        endfunction

        // bytes currently held in the ring
        function int unsigned ring_fill();
            return (wr_slot + RING_DEPTH - rd_slot) % RING_DEPTH;
        endfunction

        function void push_word(logic [2:0] kind, logic [7:0] data, logic last,
                                logic [15:0] count);
            rx_word_t w;
            w.kind  = kind;
            w.data  = data;
            w.last  = last;
            w.count = count;
            due_words.push_back(w);
        endfunction

        // update the predicted state for one accepted command word
        function void note_command(logic [1:0] act, logic [7:0] rx, logic [15:0] len);
            int unsigned fill;
            int unsigned i;
            case (act)
                ACT_BYTE:
                begin
                    if (owed != 16'd0)
                    begin
                        // request open: byte skips the ring
                        owed = owed - 16'd1;
                        push_word(KIND_DATA, rx, owed == 16'd0, req_len - owed);
                    end
                    else
                    begin
                        ring_bytes[wr_slot] = rx;
                        wr_slot = (wr_slot + 1) % RING_DEPTH;
                        if (wr_slot == rd_slot)
                        begin
                            // ring full, oldest byte dropped
                            rd_slot = (rd_slot + 1) % RING_DEPTH;
                            overruns++;
                        end
                    end
                end
                ACT_REQ:
                begin
                    // zero length wins over busy
                    if (len == 16'd0)
                        push_word(KIND_INVALID, 8'd0, 1'b0, 16'd0);
                    else if (owed != 16'd0)
                        push_word(KIND_BUSY, 8'd0, 1'b0, 16'd0);
                    else
                    begin
                        fill = ring_fill();
                        if (fill > len)
                            fill = len;
                        req_len = len;
                        for (i = 1; i <= fill; i++)
                        begin
                            push_word(KIND_DATA, ring_bytes[rd_slot], i == len, 16'(i));
                            rd_slot = (rd_slot + 1) % RING_DEPTH;
                        end
                        owed = len - 16'(fill);
                    end
                end
                ACT_CANCEL:
                begin
                    if (owed != 16'd0)
                    begin
                        req_len = req_len - owed;
                        owed    = 16'd0;
                        push_word(KIND_CANCELLED, 8'd0, 1'b0, req_len);
                    end
                    else
                        push_word(KIND_NOTHING, 8'd0, 1'b0, 16'd0);
                end
                default:
                begin
                end
            endcase
        endfunction

        // compare one result word with the oldest prediction
        function void check_word(logic [2:0] kind, logic [7:0] data, logic last,
                                 logic [15:0] count);
            rx_word_t w;
            if (due_words.size() == 0)
            begin
                $display("%0t: unexpected result word, kind %0d data 0x%02h last %0b count %0d",
                         $time, kind, data, last, count);
                errors++;
                return;
            end
            w = due_words.pop_front();
            words_by_kind[w.kind]++;
            if (kind !== w.kind)
            begin
                $display("%0t: kind mismatch, expected %0d, actual %0d", $time, w.kind, kind);
                errors++;
            end
            if (data !== w.data)
            begin
                $display("%0t: data mismatch, expected 0x%02h, actual 0x%02h",
                         $time, w.data, data);
                errors++;
            end
            if (last !== w.last)
            begin
                $display("%0t: last mismatch, expected %0b, actual %0b", $time, w.last, last);
                errors++;
            end
            if (count !== w.count)
            begin
                $display("%0t: count mismatch, expected %0d, actual %0d",
                         $time, w.count, count);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // rx_data[7:0], request_length[23:8]
    logic [1:0]  s_axis_tuser  = '0;    // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // data[7:0], delivered_count[23:8]
    logic [2:0]  m_axis_tuser;          // kind[2:0]
    logic        m_axis_tlast;          // done_res

    rx_ring_scoreboard sb;
    bit          no_idle       = 1'b0;  // set for stretches with no gaps at all
    int unsigned ready_hold    = 0;
    int unsigned cycle_count   = 0;
    int unsigned commands_sent = 0;     // accepted words, ignored ones excluded

    uart_rx_ring_with_read_request u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side back-pressure, changed at the falling edge
    always @(negedge clk)
    begin
        if (ready_hold == 0 && $urandom_range(0, 3) == 0)
            ready_hold = pick_gap();
        if (ready_hold != 0)
        begin
            m_axis_tready <= 1'b0;
            ready_hold--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // result words are taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[23:8]);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d result words still due",
                     cycle_count, sb.due_words.size());
            $display("FAIL");
            $finish;
        end
    end

    // one command word: optional gap, then hold valid until the handshake;
    // valid stays high into the next call when that call has no gap
    task automatic send_cmd(input logic [1:0] act, input logic [7:0] rx,
                            input logic [15:0] len);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, rx};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_command(act, rx, len);
        if (act != ACT_UNUSED)
            commands_sent++;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned pick;
        int unsigned burst;
        int unsigned next_switch;
        logic [15:0] len;

        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, back to back
        no_idle = 1'b1;
        send_cmd(ACT_CANCEL, 8'h00, 16'h0000);          // nothing to cancel
        send_cmd(ACT_REQ,    8'hFF, 16'h0000);          // zero length
        send_cmd(ACT_REQ,    8'h00, 16'd3);             // empty ring, all pending
        send_cmd(ACT_REQ,    8'h00, 16'hFFFF);          // busy
        send_cmd(ACT_REQ,    8'h00, 16'h0000);          // zero length beats busy
        send_cmd(ACT_BYTE,   8'h00, 16'hFFFF);          // bytes go straight out
        send_cmd(ACT_BYTE,   8'hFF, 16'h0000);
        send_cmd(ACT_BYTE,   8'h5A, 16'h0000);          // completes the request
        send_cmd(ACT_REQ,    8'hFF, 16'd4);
        send_cmd(ACT_BYTE,   8'hA5, 16'h0000);
        send_cmd(ACT_CANCEL, 8'hFF, 16'hFFFF);          // cancelled after one byte
        send_cmd(ACT_UNUSED, 8'hFF, 16'hFFFF);          // ignored
        send_cmd(ACT_BYTE,   8'h01, 16'h0000);          // into the ring
        send_cmd(ACT_BYTE,   8'h80, 16'h0000);
        send_cmd(ACT_BYTE,   8'hC3, 16'h0000);
        send_cmd(ACT_REQ,    8'h00, 16'd2);             // served from the ring
        send_cmd(ACT_REQ,    8'h00, 16'd5);             // one from ring, rest pending
        send_cmd(ACT_BYTE,   8'h7E, 16'h0000);
        send_cmd(ACT_CANCEL, 8'h00, 16'h0000);          // cancelled after two
        send_cmd(ACT_CANCEL, 8'h00, 16'h0000);          // nothing left
        send_cmd(ACT_BYTE,   8'h3C, 16'h0000);
        send_cmd(ACT_REQ,    8'h00, 16'd1);             // single byte, done at once
        no_idle = 1'b0;

        // overrun the ring, then drain it with a request far larger than it
        repeat (66) send_cmd(ACT_BYTE, 8'($urandom), 16'($urandom));
        send_cmd(ACT_REQ, 8'($urandom), 16'hFFFF);
        repeat (3) send_cmd(ACT_BYTE, 8'($urandom), 16'($urandom));
        send_cmd(ACT_CANCEL, 8'($urandom), 16'($urandom));

        // random part, idling switched off for some stretches
        next_switch = commands_sent;
        while (commands_sent < TOTAL_COMMANDS)
        begin
            if (commands_sent >= next_switch)
            begin
                no_idle     = ($urandom_range(0, 3) == 0);
                next_switch = commands_sent + 25;
            end
            pick = $urandom_range(0, 99);
            if (sb.owed != 16'd0)
            begin
                // request open: mostly feed it, sometimes poke at it
                if (pick < 70)
                    send_cmd(ACT_BYTE, 8'($urandom), 16'($urandom));
                else if (pick < 80)
                    send_cmd(ACT_CANCEL, 8'($urandom), 16'($urandom));
                else if (pick < 92)
                    send_cmd(ACT_REQ, 8'($urandom), 16'($urandom_range(1, 65535)));
                else if (pick < 96)
                    send_cmd(ACT_REQ, 8'($urandom), 16'd0);
                else
                    send_cmd(ACT_UNUSED, 8'($urandom), 16'($urandom));
            end
            else
            begin
                if (pick < 45)
                begin
                    // fill the ring, rarely far enough to overrun it
                    burst = (pick < 3) ? $urandom_range(60, 72) : $urandom_range(1, 8);
                    if (burst > TOTAL_COMMANDS - commands_sent)
                        burst = TOTAL_COMMANDS - commands_sent;
                    repeat (burst) send_cmd(ACT_BYTE, 8'($urandom), 16'($urandom));
                end
                else if (pick < 75)
                begin
                    // lengths around the fill level, a few huge ones
                    if ($urandom_range(0, 9) == 0)
                        len = 16'($urandom_range(1, 65535));
                    else
                        len = 16'($urandom_range(1, sb.ring_fill() + 4));
                    send_cmd(ACT_REQ, 8'($urandom), len);
                end
                else if (pick < 85)
                    send_cmd(ACT_CANCEL, 8'($urandom), 16'($urandom));
                else if (pick < 92)
                    send_cmd(ACT_REQ, 8'($urandom), 16'd0);
                else
                    send_cmd(ACT_UNUSED, 8'($urandom), 16'($urandom));
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // let every due word come out, then watch for strays
        while (sb.due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands accepted, %0d ring overruns, %0d busy, %0d invalid",
                 commands_sent, sb.overruns, sb.words_by_kind[KIND_BUSY],
                 sb.words_by_kind[KIND_INVALID]);
        $display("%0d data words, %0d cancels, %0d nothing to cancel, %0d errors",
                 sb.words_by_kind[KIND_DATA], sb.words_by_kind[KIND_CANCELLED],
                 sb.words_by_kind[KIND_NOTHING], sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
